>>> sv/scp_pkg.sv
`default_nettype none

package scp_pkg;

  // Default fixed-point formats.
  localparam int ANGLE_FRAC_BITS_DEF  = 24;
  localparam int RESULT_FRAC_BITS_DEF = 30;

  // Fraction bits of the internal polynomial arithmetic.
  localparam int WK = 30;

  // Function select codes.
  localparam logic OP_SIN = 1'b0;
  localparam logic OP_COS = 1'b1;

  // Range reduction constants.
  localparam logic [63:0] PIO2_Q62        = 64'h6487ED5110B4611A;
  localparam logic [63:0] PIO4_Q62        = 64'h3243F6A8885A308D;
  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;

  // Polynomial coefficients with WK fraction bits.
  localparam logic signed [31:0] SIN_K1 = -32'sd178956971;
  localparam logic signed [31:0] SIN_K2 =  32'sd8947849;
  localparam logic signed [31:0] SIN_K3 = -32'sd213044;
  localparam logic signed [31:0] COS_K1 = -32'sd536870912;
  localparam logic signed [31:0] COS_K2 =  32'sd44739243;
  localparam logic signed [31:0] COS_K3 = -32'sd1491308;
  localparam logic signed [31:0] ONE_WK =  32'sd1073741824;

  // Per-item data that travels alongside the arithmetic cells.
  typedef struct packed {
    logic               use_cos;
    logic               negate;
    logic signed [31:0] x;
    logic signed [31:0] x2;
  } scp_side_t;

endpackage

`default_nettype wire

>>> sv/sine_cosine_poly_core.sv
// Fully pipelined sine/cosine unit: one beat accepted per clock, busy is never raised.
// Pipeline: 8 reduction stages, five 4-stage multiply-add cells and 3 output stages, all
// registered, with out_valid driven from the valid flag of the last output stage.
// Throughput: one result per cycle; the receiver cannot stall, results are never held.
// Reset (rst_n low, synchronous) clears all valid flags; data registers are not reset.
`default_nettype none

module sine_cosine_poly_core #(
  parameter int ANGLE_FRAC_BITS  = scp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_opcode,
  input  wire logic signed [31:0] in_angle,
  output logic                    out_valid,
  output logic signed [31:0]      out_value
);
  import scp_pkg::*;

  localparam int NCELL = 5;

  // The front end folds the angle into [-pi/4, pi/4] by the nearest multiple of
  // pi/2 and decides, from the quadrant and the opcode, whether the sine or the
  // cosine polynomial is needed and whether the result is negated.
  logic      red_vld;
  scp_side_t red_side;

  // The polynomial runs through a row of identical multiply-add cells, each
  // computing c + a*b with rounding. The first cell squares the angle, the next
  // three are Horner steps, and the last one multiplies by x for the sine (or by
  // one, which passes the cosine sum through unchanged).
  logic               cin_vld  [0:NCELL-1];
  scp_side_t          cin_side [0:NCELL-1];
  logic signed [31:0] cin_a    [0:NCELL-1];
  logic signed [31:0] cin_b    [0:NCELL-1];
  logic signed [31:0] cin_c    [0:NCELL-1];
  logic               cout_vld [0:NCELL-1];
  scp_side_t          cout_side[0:NCELL-1];
  logic signed [31:0] cout_y   [0:NCELL-1];

  // Every beat is taken; the pipeline never backs up.
  assign busy = 1'b0;

  scp_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .in_opcode(in_opcode),
    .in_angle (in_angle),
    .out_vld  (red_vld),
    .out_side (red_side)
  );

  always_comb begin
    // Cell 0: x squared.
    cin_vld[0]  = red_vld;
    cin_side[0] = red_side;
    cin_a[0]    = red_side.x;
    cin_b[0]    = red_side.x;
    cin_c[0]    = '0;

    // Cell 1: k2 + x2 * k3; the square joins the side data here.
    cin_vld[1]     = cout_vld[0];
    cin_side[1]    = cout_side[0];
    cin_side[1].x2 = cout_y[0];
    cin_a[1]       = cout_y[0];
    cin_b[1]       = cout_side[0].use_cos ? COS_K3 : SIN_K3;
    cin_c[1]       = cout_side[0].use_cos ? COS_K2 : SIN_K2;

    // Cell 2: k1 + x2 * t.
    cin_vld[2]  = cout_vld[1];
    cin_side[2] = cout_side[1];
    cin_a[2]    = cout_side[1].x2;
    cin_b[2]    = cout_y[1];
    cin_c[2]    = cout_side[1].use_cos ? COS_K1 : SIN_K1;

    // Cell 3: 1 + x2 * t.
    cin_vld[3]  = cout_vld[2];
    cin_side[3] = cout_side[2];
    cin_a[3]    = cout_side[2].x2;
    cin_b[3]    = cout_y[2];
    cin_c[3]    = ONE_WK;

    // Cell 4: x * t for the sine, exact pass-through for the cosine.
    cin_vld[4]  = cout_vld[3];
    cin_side[4] = cout_side[3];
    cin_a[4]    = cout_side[3].use_cos ? ONE_WK : cout_side[3].x;
    cin_b[4]    = cout_y[3];
    cin_c[4]    = '0;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    scp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (cin_vld[i]),
      .in_side (cin_side[i]),
      .in_a    (cin_a[i]),
      .in_b    (cin_b[i]),
      .in_c    (cin_c[i]),
      .out_vld (cout_vld[i]),
      .out_side(cout_side[i]),
      .out_y   (cout_y[i])
    );
  end

  // Final sign, rounding to the output format and saturation to plus or minus one.
  scp_out #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cout_vld[NCELL-1]),
    .in_res   (cout_y[NCELL-1]),
    .in_negate(cout_side[NCELL-1].negate),
    .out_valid(out_valid),
    .out_value(out_value)
  );

endmodule

`default_nettype wire

>>> sv/scp_reduce.sv
`default_nettype none

module scp_reduce #(
  parameter int ANGLE_FRAC_BITS = scp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire logic               in_opcode,
  input  wire logic signed [31:0] in_angle,
  output logic                    out_vld,
  output scp_pkg::scp_side_t      out_side
);
  import scp_pkg::*;

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int G  = F + 24;
  localparam int S  = G - WK;
  localparam int NW = 32 - F;
  localparam int PW = G + 1;
  localparam int RW = 58;
  localparam logic [63:0] PIO4  = (PIO4_Q62 + (64'd1 << (61 - F))) >> (62 - F);
  localparam logic [63:0] PIO2G = (PIO2_Q62 + (64'd1 << (61 - G))) >> (62 - G);
  localparam logic [RW-1:0] XHALF = RW'(1) << (S - 1);

  logic [7:0] vld_r;

  // Stage 1: magnitude.
  logic        s1_op_r, s1_neg_r;
  logic [31:0] s1_amag_r, s1_amag_nxt;
  // Stage 2: scaled by 2/pi.
  logic        s2_op_r, s2_neg_r, s2_big_r;
  logic [31:0] s2_amag_r;
  logic [63:0] s2_prod_r;
  // Stage 3: quadrant count.
  logic          s3_op_r, s3_neg_r;
  logic [31:0]   s3_amag_r;
  logic [NW:0]   n_sum;
  logic [NW-1:0] s3_n_r;
  // Stage 4: multiple of pi/2.
  logic             s4_op_r, s4_neg_r;
  logic [31:0]      s4_amag_r;
  logic [1:0]       s4_q_r;
  logic [NW+PW-1:0] s4_np_r;
  // Stage 5: remainder.
  logic                 s5_neg_r, s5_cos_r, s5_negate_r;
  logic signed [RW-1:0] s5_r_r;
  // Stage 6: remainder magnitude.
  logic          s6_neg_r, s6_cos_r, s6_negate_r, s6_rsign_r;
  logic [RW-1:0] s6_rmag_r;
  // Stage 7: rounded reduced angle.
  logic          s7_cos_r, s7_negate_r, s7_xneg_r;
  logic [RW-1:0] x_sum;
  logic [31:0]   s7_xmag_r;
  // Stage 8: signed reduced angle.
  logic               s8_cos_r, s8_negate_r;
  logic signed [31:0] s8_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:0], in_vld};
    end
  end

  assign s1_amag_nxt = in_angle[31] ? (~$unsigned(in_angle) + 32'd1) : $unsigned(in_angle);
  assign n_sum       = s2_prod_r[63:F+31] + (NW+1)'(1);
  assign x_sum       = s6_rmag_r + XHALF;

  always_ff @(posedge clk) begin
    s1_op_r   <= in_opcode;
    s1_neg_r  <= in_angle[31];
    s1_amag_r <= s1_amag_nxt;

    s2_op_r   <= s1_op_r;
    s2_neg_r  <= s1_neg_r;
    s2_amag_r <= s1_amag_r;
    s2_big_r  <= s1_amag_r > PIO4[31:0];
    s2_prod_r <= 64'(s1_amag_r) * 64'(TWO_OVER_PI_Q32);

    s3_op_r   <= s2_op_r;
    s3_neg_r  <= s2_neg_r;
    s3_amag_r <= s2_amag_r;
    s3_n_r    <= s2_big_r ? n_sum[NW:1] : '0;

    s4_op_r   <= s3_op_r;
    s4_neg_r  <= s3_neg_r;
    s4_amag_r <= s3_amag_r;
    s4_q_r    <= s3_neg_r ? (~s3_n_r[1:0] + 2'd1) : s3_n_r[1:0];
    s4_np_r   <= (NW+PW)'(s3_n_r) * (NW+PW)'(PIO2G[PW-1:0]);

    s5_neg_r <= s4_neg_r;
    s5_r_r   <= $signed({2'b00, s4_amag_r, 24'd0}) - $signed({1'b0, s4_np_r});
    if (s4_op_r == OP_SIN) begin
      s5_cos_r    <= s4_q_r[0];
      s5_negate_r <= s4_q_r[1];
    end else begin
      s5_cos_r    <= ~s4_q_r[0];
      s5_negate_r <= s4_q_r[0] ^ s4_q_r[1];
    end

    s6_neg_r    <= s5_neg_r;
    s6_cos_r    <= s5_cos_r;
    s6_negate_r <= s5_negate_r;
    s6_rsign_r  <= s5_r_r[RW-1];
    s6_rmag_r   <= s5_r_r[RW-1] ? (RW'(0) - $unsigned(s5_r_r)) : $unsigned(s5_r_r);

    s7_cos_r    <= s6_cos_r;
    s7_negate_r <= s6_negate_r;
    s7_xneg_r   <= s6_rsign_r ^ s6_neg_r;
    s7_xmag_r   <= x_sum[S+31:S];

    s8_cos_r    <= s7_cos_r;
    s8_negate_r <= s7_negate_r;
    s8_x_r      <= s7_xneg_r ? $signed(32'd0 - s7_xmag_r) : $signed(s7_xmag_r);
  end

  assign out_vld          = vld_r[7];
  assign out_side.use_cos = s8_cos_r;
  assign out_side.negate  = s8_negate_r;
  assign out_side.x       = s8_x_r;
  assign out_side.x2      = '0;

endmodule

`default_nettype wire

>>> sv/scp_cell.sv
`default_nettype none

module scp_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire scp_pkg::scp_side_t in_side,
  input  wire logic signed [31:0] in_a,
  input  wire logic signed [31:0] in_b,
  input  wire logic signed [31:0] in_c,
  output logic                    out_vld,
  output scp_pkg::scp_side_t      out_side,
  output logic signed [31:0]      out_y
);
  import scp_pkg::*;

  // Computes c + round(a * b / 2^WK), rounding the magnitude half away from zero.

  logic [3:0]  vld_r;
  scp_side_t   side_r [0:3];

  logic               sa_sgn_r;
  logic [31:0]        sa_amag_r, sa_bmag_r;
  logic signed [31:0] sa_c_r;

  logic               sb_sgn_r;
  logic [63:0]        sb_prod_r;
  logic signed [31:0] sb_c_r;

  logic               sc_sgn_r;
  logic [63:0]        rnd_sum;
  logic [32:0]        sc_rnd_r;
  logic signed [31:0] sc_c_r;

  logic signed [33:0] acc;
  logic signed [31:0] y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  assign rnd_sum = sb_prod_r + (64'd1 << (WK - 1));
  assign acc = sc_sgn_r ? ($signed({{2{sc_c_r[31]}}, sc_c_r}) - $signed({1'b0, sc_rnd_r}))
                        : ($signed({{2{sc_c_r[31]}}, sc_c_r}) + $signed({1'b0, sc_rnd_r}));

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    side_r[1] <= side_r[0];
    side_r[2] <= side_r[1];
    side_r[3] <= side_r[2];

    sa_sgn_r  <= in_a[31] ^ in_b[31];
    sa_amag_r <= in_a[31] ? (32'd0 - $unsigned(in_a)) : $unsigned(in_a);
    sa_bmag_r <= in_b[31] ? (32'd0 - $unsigned(in_b)) : $unsigned(in_b);
    sa_c_r    <= in_c;

    sb_sgn_r  <= sa_sgn_r;
    sb_prod_r <= 64'(sa_amag_r) * 64'(sa_bmag_r);
    sb_c_r    <= sa_c_r;

    sc_sgn_r  <= sb_sgn_r;
    sc_rnd_r  <= 33'(rnd_sum >> WK);
    sc_c_r    <= sb_c_r;

    y_r <= acc[31:0];
  end

  assign out_vld  = vld_r[3];
  assign out_side = side_r[3];
  assign out_y    = y_r;

endmodule

`default_nettype wire

>>> sv/scp_out.sv
`default_nettype none

module scp_out #(
  parameter int RESULT_FRAC_BITS = scp_pkg::RESULT_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire logic signed [31:0] in_res,
  input  wire logic               in_negate,
  output logic                    out_valid,
  output logic signed [31:0]      out_value
);
  import scp_pkg::*;

  localparam int SH = WK - RESULT_FRAC_BITS;
  localparam logic [32:0] HALF  = (33'd1 << SH) >> 1;
  localparam logic [32:0] ONE_R = 33'd1 << RESULT_FRAC_BITS;

  logic [2:0]  vld_r;
  logic        s1_sign_r, s2_sign_r;
  logic [31:0] s1_mag_r;
  logic [32:0] rnd_sum, rnd_val;
  logic [32:0] s2_mag_r;
  logic [32:0] neg_val;
  logic signed [31:0] value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  assign rnd_sum = {1'b0, s1_mag_r} + HALF;
  assign rnd_val = rnd_sum >> SH;
  assign neg_val = 33'd0 - s2_mag_r;

  always_ff @(posedge clk) begin
    s1_sign_r <= in_res[31] ^ in_negate;
    s1_mag_r  <= in_res[31] ? (32'd0 - $unsigned(in_res)) : $unsigned(in_res);

    s2_sign_r <= s1_sign_r;
    s2_mag_r  <= (rnd_val > ONE_R) ? ONE_R : rnd_val;

    value_r <= s2_sign_r ? $signed(neg_val[31:0]) : $signed(s2_mag_r[31:0]);
  end

  assign out_valid = vld_r[2];
  assign out_value = value_r;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import scp_pkg::*;

  // Formats of the instance under test (package defaults).
  localparam int AF = ANGLE_FRAC_BITS_DEF;
  localparam int RF = RESULT_FRAC_BITS_DEF;
  // Fraction bits of the reduction remainder.
  localparam int G = AF + 24;

  // pi/4 as the reduction threshold, in the angle format.
  localparam logic [63:0] PIO4_THR = (PIO4_Q62 + (64'd1 << (61 - AF))) >> (62 - AF);
  // pi/2 with G fraction bits, used to take away whole quadrants.
  localparam logic [63:0] PIO2_G = (PIO2_Q62 + (64'd1 << (61 - G))) >> (62 - G);

  // Margin after the last beat, longer than the pipeline is deep.
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic               op;
    logic signed [31:0] angle;
    logic signed [31:0] value;
  } trig_beat_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               in_opcode = 1'b0;
  logic signed [31:0] in_angle  = '0;
  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_value;

  // Results still owed by the pipeline, oldest first.
  trig_beat_t trig_due_q[$];
  int         err_count   = 0;
  int         cycle_count = 0;

  sine_cosine_poly_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_opcode (in_opcode),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_value (out_value)
  );

  always #10 clk = ~clk;

  // Right shift of a magnitude with round to nearest, ties away from zero, then the sign
  // is applied.
  function automatic longint round_shift(logic neg, logic [63:0] mag, int s);
    logic [63:0] m;
    m = mag;
    if (s > 0 && s < 64) begin
      m = (mag + (64'd1 << (s - 1))) >> s;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint signed_round_shift(longint v, int s);
    logic        neg;
    logic [63:0] mag;
    neg = v < 0;
    mag = neg ? -v : v;
    return round_shift(neg, mag, s);
  endfunction

  // Sign-magnitude product of two WK-fraction numbers, rounded back to WK bits.
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = ma * mb;
    return round_shift((a < 0) != (b < 0), p, WK);
  endfunction

  // Expected sine or cosine of one angle, bit exact.
  function automatic logic signed [31:0] trig_value(logic op, logic [31:0] angle);
    logic        neg;
    logic [31:0] amag;
    logic [63:0] prod;
    logic [63:0] quad;
    logic [1:0]  q;
    logic        use_cos;
    logic        negate;
    longint      rem;
    longint      x;
    longint      x2;
    longint      t;
    longint      res;
    longint      sat;
    neg  = angle[31];
    amag = neg ? -angle : angle;
    quad = '0;
    // Outside [-pi/4, pi/4] the nearest multiple of pi/2 is taken away.
    if ({32'd0, amag} > PIO4_THR) begin
      prod = {32'd0, amag} * {32'd0, TWO_OVER_PI_Q32};
      quad = (prod + (64'd1 << (AF + 31))) >> (AF + 32);
    end
    rem = longint'({32'd0, amag} << 24) - longint'(quad) * longint'(PIO2_G);
    x   = signed_round_shift(rem, G - WK);
    if (neg) begin
      x    = -x;
      quad = -quad;
    end
    q = quad[1:0];
    if (op == OP_SIN) begin
      use_cos = q[0];
      negate  = q[1];
    end else begin
      use_cos = !q[0];
      negate  = (q == 2'd1) || (q == 2'd2);
    end
    x2 = fx_mul(x, x);
    if (use_cos) begin
      t   = longint'(COS_K3);
      t   = longint'(COS_K2) + fx_mul(x2, t);
      t   = longint'(COS_K1) + fx_mul(x2, t);
      res = longint'(ONE_WK) + fx_mul(x2, t);
    end else begin
      t   = longint'(SIN_K3);
      t   = longint'(SIN_K2) + fx_mul(x2, t);
      t   = longint'(SIN_K1) + fx_mul(x2, t);
      t   = longint'(ONE_WK) + fx_mul(x2, t);
      res = fx_mul(x, t);
    end
    if (negate) begin
      res = -res;
    end
    res = signed_round_shift(res, WK - RF);
    sat = 64'sd1 << RF;
    if (res > sat) begin
      res = sat;
    end
    if (res < -sat) begin
      res = -sat;
    end
    return res[31:0];
  endfunction

  // Angles are drawn from four pools: the whole 32-bit range, the first few quadrants,
  // the close neighborhood of multiples of pi/4 (where the quadrant rounding flips), and
  // moderate angles up to eight radians.
  function automatic logic signed [31:0] rand_angle();
    logic [31:0] mag;
    case ($urandom_range(3))
      0: begin
        return $urandom;
      end
      1: begin
        mag = $urandom_range(8 * PIO4_THR[31:0]);
      end
      2: begin
        mag = $urandom_range(160, 1) * PIO4_THR[31:0] + $urandom_range(8) - 4;
      end
      default: begin
        mag = $urandom_range(32'h0800_0000);
      end
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic report(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endtask

  // Drives one beat and holds it until the core takes it. The caller is at a rising edge,
  // and so is this task on return; start stays high so the next beat can follow directly.
  task automatic send_beat(input logic op, input logic signed [31:0] angle);
    trig_beat_t beat;
    start     <= 1'b1;
    in_opcode <= op;
    in_angle  <= angle;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    beat.op    = op;
    beat.angle = angle;
    beat.value = trig_value(op, angle);
    trig_due_q.push_back(beat);
  endtask

  // Each cycle the sender stays idle with the given chance in a hundred. While idle, the
  // data ports carry junk, which the core must ignore.
  task automatic idle_cycles(input int pct);
    while ($urandom_range(99) < pct) begin
      start     <= 1'b0;
      in_opcode <= $urandom_range(1);
      in_angle  <= $urandom;
      @(posedge clk);
    end
  endtask

  task automatic run_random(input int count, input int idle_pct);
    repeat (count) begin
      idle_cycles(idle_pct);
      send_beat($urandom_range(1), rand_angle());
    end
  endtask

  // Zero, the reduction threshold on both sides, exact and near quadrant boundaries, the
  // rounding point between quadrants one and two, and the extremes of the angle field,
  // including the most negative angle, whose magnitude does not fit in 31 bits.
  task automatic test_directed_angles();
    logic signed [31:0] corner [12];
    logic [31:0]        p4;
    p4     = PIO4_THR[31:0];
    corner = '{32'sd0, -32'sd1, p4, p4 + 1, -(p4 + 1), 2 * p4, 3 * p4, 3 * p4 + 1,
               -(4 * p4), 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0001};
    foreach (corner[i]) begin
      send_beat(OP_SIN, corner[i]);
      send_beat(OP_COS, corner[i]);
    end
  endtask

  // The sender stops until the pipeline has delivered every result it owes.
  task automatic test_drain_pause();
    start <= 1'b0;
    @(posedge clk);
    while (trig_due_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_random_sparse_sender();
    run_random(500, 37);
  endtask

  task automatic test_random_slow_sender();
    run_random(500, 64);
  endtask

  task automatic test_random_back_to_back();
    run_random(550, 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_angles();
    test_drain_pause();
    test_random_sparse_sender();
    test_random_slow_sender();
    test_random_back_to_back();

    // Let the pipeline empty, then give it a few more cycles to show any stray beat.
    test_drain_pause();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Every strobed result is matched against the oldest owed result. Values are read at the
  // rising edge, before the core's registers move on.
  always @(posedge clk) begin : check_results
    trig_beat_t owed;
    if (rst_n && out_valid) begin
      if (trig_due_q.size() == 0) begin
        report($sformatf("unexpected result beat: value %0d", out_value));
      end else begin
        owed = trig_due_q.pop_front();
        if (out_value !== owed.value) begin
          report($sformatf("mismatch: op %0d angle %0d expected %0d got %0d",
                           owed.op, owed.angle, owed.value, out_value));
        end
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

endmodule
